// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled while reset is asserted
`define MCSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define MCSC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/mcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsc_pkg
// shared types and fixed field widths of the subset cover search core
// ----------------------------------------------------------------------------
package mcsc_pkg;

  // fixed field widths
  localparam int unsigned VALUE_W    = 17;
  localparam int unsigned ITEM_CNT_W = 4;
  localparam int unsigned DIM_CNT_W  = 5;
  localparam int unsigned THR_W      = 17;
  localparam int unsigned COST_W     = 21;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // table load position, saturating
  localparam int unsigned   POS_W   = 8;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ADDR,
    S_ACC,
    S_EVAL,
    S_DONE
  } state_e;

endpackage

// ===== rtl/core/min_cost_subset_cover_search_core.sv =====
// ----------------------------------------------------------------------------
// min_cost_subset_cover_search_core
// minimum-cost covering subset search over a loaded item table
// ----------------------------------------------------------------------------
// The table streams in one value per transaction and one per cycle while
// in_ready_o is high, row by row: the item cost, then one contribution per
// dimension. The transaction with is_last set starts the search, and
// in_ready_o stays low until it ends. The search walks every nonempty subset
// of the items with one adder and one read port of the table memory: per
// subset it sums the costs and then each dimension column in turn, visiting
// every item position, adding each selected item and evaluating each column,
// stopping a subset at its first short column or once its cost cannot beat
// the best so far. A write to dim_count takes the core away from new table
// values while a serial divider re-derives the row and column of the load
// position. The result sits in an output register, so loading of the next
// table may begin while it waits to be taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module min_cost_subset_cover_search_core #(
  parameter int unsigned MAX_ITEMS  = 12,
  parameter int unsigned MAX_DIMS   = 16,
  parameter int unsigned VALUE_BITS = 17
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // table value channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mcsc_pkg::VALUE_W-1:0]     value_i,
  input  logic                             is_last_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             found_o,
  output logic [mcsc_pkg::COST_W-1:0]      min_cost_o,
  // register write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mcsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mcsc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mcsc_pkg::*;

  // stored value width, masked to VALUE_BITS
  localparam int unsigned STORE_W   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  // sums of up to MAX_ITEMS stored values
  localparam int unsigned ACC_W     = STORE_W + $clog2(MAX_ITEMS + 1);
  // one table row: cost then MAX_DIMS contributions
  localparam int unsigned ROW_LEN   = MAX_DIMS + 1;
  localparam int unsigned MEM_DEPTH = MAX_ITEMS * ROW_LEN;
  localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  // column index and stride, up to MAX_DIMS + 1
  localparam int unsigned STR_W     = $clog2(MAX_DIMS + 2);
  // item position inside a subset mask
  localparam int unsigned IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned NCNT_W    = $clog2(MAX_ITEMS + 1);

  // registers
  logic [ITEM_CNT_W-1:0] item_count_q, item_count_d;
  logic [DIM_CNT_W-1:0]  dim_count_q, dim_count_d;
  logic [THR_W-1:0]      threshold_q, threshold_d;

  state_e                state_q, state_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [POS_W-1:0]      row_q, row_d;
  logic [STR_W-1:0]      col_q, col_d;

  logic [MAX_ITEMS-1:0]  subset_q, subset_d;
  logic [IDX_W-1:0]      j_q, j_d;
  logic [STR_W-1:0]      c_q, c_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [ACC_W-1:0]      total_q, total_d;
  logic [ACC_W-1:0]      best_q, best_d;
  logic                  found_q, found_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_found_q, out_found_d;
  logic [COST_W-1:0]     out_cost_q, out_cost_d;

  // table memory
  logic [STORE_W-1:0]    mem [MEM_DEPTH];
  logic [STORE_W-1:0]    rd_data_q;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic                  mem_we;

  // handshakes and derived config
  logic                  in_fire, out_fire, cfg_fire;
  logic [NCNT_W-1:0]     n_items;
  logic [STR_W-1:0]      n_dims;
  logic [STR_W-1:0]      stride;
  logic [MAX_ITEMS-1:0]  full_mask;
  logic                  last_j;
  logic                  row_in_table;

  // position divider
  logic                  div_start;
  logic                  div_done;
  logic [POS_W-1:0]      div_row;
  logic [STR_W-1:0]      div_col;

  // counts above the table size saturate
  always_comb begin
    n_items = (32'(item_count_q) > 32'(MAX_ITEMS)) ? NCNT_W'(MAX_ITEMS)
                                                    : NCNT_W'(item_count_q);
    n_dims  = (32'(dim_count_q) > 32'(MAX_DIMS)) ? STR_W'(MAX_DIMS)
                                                  : STR_W'(dim_count_q);
  end

  assign stride       = n_dims + 1'b1;
  assign full_mask    = MAX_ITEMS'((33'd1 << n_items) - 33'd1);
  assign last_j       = 32'(j_q) == 32'(n_items) - 32'd1;
  assign row_in_table = 32'(row_q) < 32'(MAX_ITEMS);

  // config has priority over a table value in the same cycle
  assign cfg_ready_o = state_q == S_IDLE;
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign div_start   = cfg_fire && (cfg_index_i == CFG_DIM_COUNT);

  // memory addressing: row-major, fixed row length
  assign wr_addr = AW'(32'(row_q) * ROW_LEN + 32'(col_q));
  assign rd_addr = AW'(32'(j_q) * ROW_LEN + 32'(c_q));
  assign mem_we  = in_fire && row_in_table;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= value_i[STORE_W-1:0];
    end
    rd_data_q <= mem[rd_addr];
  end

  mcsc_posdiv #(
    .STR_W (STR_W)
  ) u_posdiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .pos_i    (pos_q),
    .stride_i (stride),
    .done_o   (div_done),
    .row_o    (div_row),
    .col_o    (div_col)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    item_count_d = item_count_q;
    dim_count_d  = dim_count_q;
    threshold_d  = threshold_q;
    pos_d        = pos_q;
    row_d        = row_q;
    col_d        = col_q;
    subset_d     = subset_q;
    j_d          = j_q;
    c_d          = c_q;
    acc_d        = acc_q;
    total_d      = total_q;
    best_d       = best_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_found_d  = out_found_q;
    out_cost_d   = out_cost_q;

    // register writes
    if (cfg_fire) begin
      case (cfg_index_i)
        CFG_ITEM_COUNT: item_count_d = cfg_data_i[ITEM_CNT_W-1:0];
        CFG_DIM_COUNT: begin
          dim_count_d = cfg_data_i[DIM_CNT_W-1:0];
          state_d     = S_DIV;
        end
        CFG_THRESHOLD:  threshold_d = cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // advance the load position unless saturated
          if (pos_q != POS_MAX) begin
            pos_d = pos_q + 1'b1;
            if (col_q == n_dims) begin
              col_d = '0;
              row_d = row_q + 1'b1;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
          if (is_last_i) begin
            pos_d    = '0;
            row_d    = '0;
            col_d    = '0;
            subset_d = MAX_ITEMS'(1);
            j_d      = '0;
            c_d      = '0;
            acc_d    = '0;
            found_d  = 1'b0;
            // no items means no nonempty subset
            state_d  = (n_items == '0) ? S_DONE : S_ADDR;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          row_d   = div_row;
          col_d   = div_col;
          state_d = S_IDLE;
        end
      end

      S_ADDR: begin
        // read issued for a selected item, skip the rest
        if (subset_q[j_q]) begin
          state_d = S_ACC;
        end else if (last_j) begin
          state_d = S_EVAL;
        end else begin
          j_d = j_q + 1'b1;
        end
      end

      S_ACC: begin
        acc_d = acc_q + ACC_W'(rd_data_q);
        if (last_j) begin
          state_d = S_EVAL;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_ADDR;
        end
      end

      S_EVAL: begin
        logic next_subset;
        next_subset = 1'b0;
        j_d         = '0;
        acc_d       = '0;
        state_d     = S_ADDR;
        if (c_q == '0) begin
          total_d = acc_q;
          if (found_q && (acc_q >= best_q)) begin
            // cannot beat the best cost
            next_subset = 1'b1;
          end else if (n_dims == '0) begin
            best_d      = acc_q;
            found_d     = 1'b1;
            next_subset = 1'b1;
          end else begin
            c_d = c_q + 1'b1;
          end
        end else if (32'(acc_q) < 32'(threshold_q)) begin
          // short column, subset fails
          next_subset = 1'b1;
        end else if (c_q == n_dims) begin
          best_d      = total_q;
          found_d     = 1'b1;
          next_subset = 1'b1;
        end else begin
          c_d = c_q + 1'b1;
        end
        if (next_subset) begin
          c_d = '0;
          if (subset_q == full_mask) begin
            state_d = S_DONE;
          end else begin
            subset_d = subset_q + 1'b1;
          end
        end
      end

      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_found_d = found_q;
          out_cost_d  = found_q ? COST_W'(best_q) : '0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      item_count_q <= ITEM_CNT_W'(1);
      dim_count_q  <= DIM_CNT_W'(1);
      threshold_q  <= '0;
      pos_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
      subset_q     <= '0;
      j_q          <= '0;
      c_q          <= '0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      item_count_q <= item_count_d;
      dim_count_q  <= dim_count_d;
      threshold_q  <= threshold_d;
      pos_q        <= pos_d;
      row_q        <= row_d;
      col_q        <= col_d;
      subset_q     <= subset_d;
      j_q          <= j_d;
      c_q          <= c_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    total_q    <= total_d;
    best_q     <= best_d;
    out_found_q <= out_found_d;
    out_cost_q <= out_cost_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign min_cost_o  = out_cost_q;

  // checks
  `MCSC_ASSERT(a_no_cost_without_find, (out_valid_o && !found_o) |-> (min_cost_o == '0), "cost reported without a qualifying subset")
  `MCSC_NEVER(a_write_in_table, mem_we && (32'(row_q) >= 32'(MAX_ITEMS)), "table write beyond the last row")
  `MCSC_ASSERT(a_scan_in_range, (state_q == S_ADDR || state_q == S_ACC) |-> (32'(j_q) < 32'(n_items)), "item scan past the item count")
  `MCSC_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result raised outside the done step")

endmodule

// ===== rtl/core/mcsc_posdiv.sv =====
// ----------------------------------------------------------------------------
// mcsc_posdiv
// restoring divider: splits the load position into row and column
// ----------------------------------------------------------------------------
module mcsc_posdiv #(
  parameter int unsigned STR_W = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mcsc_pkg::POS_W-1:0] pos_i,
  input  logic [STR_W-1:0]          stride_i,
  output logic                      done_o,
  output logic [mcsc_pkg::POS_W-1:0] row_o,
  output logic [STR_W-1:0]          col_o
);
  import mcsc_pkg::*;

  localparam int unsigned CNT_W = $clog2(POS_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] dq_q, dq_d;
  logic [STR_W-1:0] rem_q, rem_d;
  logic [STR_W:0]   trial;
  logic             fits;

  // one quotient bit per cycle
  always_comb begin
    trial  = {rem_q, dq_q[POS_W-1]};
    fits   = trial >= {1'b0, stride_i};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = pos_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dq_d  = {dq_q[POS_W-2:0], fits};
      rem_d = fits ? STR_W'(trial - {1'b0, stride_i}) : STR_W'(trial);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(POS_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign row_o  = dq_q;
  assign col_o  = rem_q;

endmodule
